// ===== rtl/apcs_pkg.sv =====
// apcs_pkg: shared constants, codes and types of the ATA PIO command sequencer.
// No dependencies; every other file of the block but apcs_if imports it.
`default_nettype none

package apcs_pkg;

  // geometry and limits
  localparam int WORDS_PER_SECTOR = 256;
  localparam int MAX_ATTEMPTS     = 3;
  localparam int NUM_DRIVES       = 4;

  localparam int WIDX_W = (WORDS_PER_SECTOR > 1) ? $clog2(WORDS_PER_SECTOR) : 1;
  localparam logic [WIDX_W-1:0] LAST_WORD = WIDX_W'(WORDS_PER_SECTOR - 1);
  localparam logic [2:0] DRIVES_LIM  = 3'(NUM_DRIVES);
  localparam logic [1:0] ATTEMPT_LIM = 2'(MAX_ATTEMPTS);

  // results one item can cause: the six task file writes at most
  localparam int BURST_MAX = 6;
  localparam int CNT_W     = 3;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESENT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_POLL    = 1'b1;
  localparam logic [15:0] POLL_LIMIT_RST = 16'd50000;

  // input word kinds
  localparam logic [1:0] KIND_START  = 2'd0;
  localparam logic [1:0] KIND_STATUS = 2'd1;
  localparam logic [1:0] KIND_DATA   = 2'd2;

  // result word kinds
  localparam logic [2:0] OK_REG_WR  = 3'd0;
  localparam logic [2:0] OK_ERR_RD  = 3'd1;
  localparam logic [2:0] OK_TO_HOST = 3'd2;
  localparam logic [2:0] OK_TO_DEV  = 3'd3;
  localparam logic [2:0] OK_DONE    = 3'd4;

  // task file offsets
  localparam logic [2:0] REG_DATA    = 3'd0;
  localparam logic [2:0] REG_ERROR   = 3'd1;
  localparam logic [2:0] REG_COUNT   = 3'd2;
  localparam logic [2:0] REG_LBA_LO  = 3'd3;
  localparam logic [2:0] REG_LBA_MID = 3'd4;
  localparam logic [2:0] REG_LBA_HI  = 3'd5;
  localparam logic [2:0] REG_HEAD    = 3'd6;
  localparam logic [2:0] REG_CMD     = 3'd7;

  // completion codes
  localparam logic [2:0] RC_OK       = 3'd0;
  localparam logic [2:0] RC_BSY_TO   = 3'd1;
  localparam logic [2:0] RC_DRQ_TO   = 3'd2;
  localparam logic [2:0] RC_ERROR    = 3'd3;
  localparam logic [2:0] RC_FAULT    = 3'd4;
  localparam logic [2:0] RC_FLOATING = 3'd5;
  localparam logic [2:0] RC_REJECT   = 3'd6;

  // commands and status bits
  localparam logic [7:0] CMD_READ   = 8'h20;
  localparam logic [7:0] CMD_WRITE  = 8'h30;
  localparam logic [7:0] STAT_FLOAT = 8'hFF;
  localparam int ST_ERR = 0;
  localparam int ST_DRQ = 3;
  localparam int ST_DF  = 5;
  localparam int ST_BSY = 7;

  // device select with the lba mode bit set
  localparam logic [7:0] SEL_MASTER = 8'hE0;
  localparam logic [7:0] SEL_SLAVE  = 8'hF0;

  typedef struct packed {
    logic [1:0]  kind;
    logic        op_write;
    logic [1:0]  drive;
    logic [27:0] lba;
    logic [7:0]  sector_count;
    logic [7:0]  status_byte;
    logic [15:0] data_word;
  } item_t;

  typedef struct packed {
    logic [2:0]  out_kind;
    logic        channel;
    logic [2:0]  reg_offset;
    logic [15:0] value;
    logic [2:0]  result_code;
    logic        last;
  } result_t;

  // first result in items[0]
  typedef struct packed {
    logic [CNT_W-1:0]             n;
    result_t [BURST_MAX-1:0]      items;
  } burst_t;

  typedef struct packed {
    logic [3:0]  present_mask;
    logic [15:0] poll_limit;
  } cfg_t;

endpackage

`default_nettype wire

// ===== rtl/apcs_if.sv =====
// apcs_in_if / apcs_out_if: valid/ready channels of the command sequencer.
// Field widths follow apcs_pkg without importing it; no dependencies.
`default_nettype none

interface apcs_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic        op_write;
  logic [1:0]  drive;
  logic [27:0] lba;
  logic [7:0]  sector_count;
  logic [7:0]  status_byte;
  logic [15:0] data_word;

  modport source (output valid, kind, op_write, drive, lba, sector_count, status_byte,
                  data_word, input ready);
  modport sink (input valid, kind, op_write, drive, lba, sector_count, status_byte,
                data_word, output ready);
endinterface

interface apcs_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  out_kind;
  logic        channel;
  logic [2:0]  reg_offset;
  logic [15:0] value;
  logic [2:0]  result_code;
  logic        last;

  modport source (output valid, out_kind, channel, reg_offset, value, result_code, last,
                  input ready);
  modport sink (input valid, out_kind, channel, reg_offset, value, result_code, last,
                output ready);
endinterface

`default_nettype wire

// ===== rtl/ata_pio_command_sequencer.sv =====
// ata_pio_command_sequencer: top level of the ATA PIO LBA28 host sequencer.
// Depends on apcs_pkg, apcs_if, apcs_core and apcs_burst.
//
//   port     direction  words
//   in_ch    sink       start commands, status samples, data words
//   out_ch   source     register writes, error reads, data words, done
//   cfg_*    write      present_mask (index 0), poll_limit (index 1)
//
// an input word is evaluated in the cycle it is taken; its results enter a
// result register the next cycle, leaving one per cycle while out_ch is ready
// a word with one result or none can be taken every cycle while out_ch is
// ready; a word causing the six task file writes holds in_ch.ready low until
// the last of those writes is being taken
// in_ch.ready stays high while the last pending result is being taken
// synchronous active-low reset clears the command state and the result count
`default_nettype none

module ata_pio_command_sequencer (
  input  logic                               clk,
  input  logic                               rst_n,
  apcs_in_if.sink                            in_ch,
  apcs_out_if.source                         out_ch,
  input  logic                               cfg_we,
  input  logic [apcs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [apcs_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import apcs_pkg::*;

  cfg_t   cfg_r;
  item_t  item;
  burst_t burst;
  logic   fire;
  logic   take_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.present_mask <= 4'h0;
      cfg_r.poll_limit   <= POLL_LIMIT_RST;
    end else if (cfg_we) begin
      if (cfg_index == CFG_PRESENT) begin
        cfg_r.present_mask <= cfg_wdata[3:0];
      end else begin
        cfg_r.poll_limit <= cfg_wdata;
      end
    end
  end

  assign item.kind         = in_ch.kind;
  assign item.op_write     = in_ch.op_write;
  assign item.drive        = in_ch.drive;
  assign item.lba          = in_ch.lba;
  assign item.sector_count = in_ch.sector_count;
  assign item.status_byte  = in_ch.status_byte;
  assign item.data_word    = in_ch.data_word;

  assign in_ch.ready = take_ok;
  assign fire        = in_ch.valid && take_ok;

  apcs_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg_r),
    .fire  (fire),
    .item  (item),
    .burst (burst)
  );

  apcs_burst u_burst (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (fire),
    .burst   (burst),
    .take_ok (take_ok),
    .out_ch  (out_ch)
  );

endmodule

`default_nettype wire

// ===== rtl/apcs_core.sv =====
// apcs_core: command state registers and the single-pass next-state logic that
// turns one accepted word into a burst of results. Depends on apcs_pkg.
`default_nettype none

module apcs_core (
  input  logic            clk,
  input  logic            rst_n,
  input  apcs_pkg::cfg_t  cfg,
  input  logic            fire,
  input  apcs_pkg::item_t item,
  output apcs_pkg::burst_t burst
);
  import apcs_pkg::*;

  localparam logic [3:0] PH_IDLE       = 4'd0;
  localparam logic [3:0] PH_RD_RECOVER = 4'd1;
  localparam logic [3:0] PH_RD_PRE     = 4'd2;
  localparam logic [3:0] PH_RD_DRQ     = 4'd3;
  localparam logic [3:0] PH_RD_DATA    = 4'd4;
  localparam logic [3:0] PH_RD_POST    = 4'd5;
  localparam logic [3:0] PH_WR_READY   = 4'd6;
  localparam logic [3:0] PH_WR_DRQ     = 4'd7;
  localparam logic [3:0] PH_WR_DATA    = 4'd8;
  localparam logic [3:0] PH_WR_FINAL   = 4'd9;

  logic [3:0]        phase_r, phase_nxt;
  logic [1:0]        drive_r, drive_nxt;
  logic [27:0]       lba_r, lba_nxt;
  logic [7:0]        left_r, left_nxt;
  logic [WIDX_W-1:0] widx_r, widx_nxt;
  logic [15:0]       pc_r, pc_nxt;
  logic [1:0]        attempt_r, attempt_nxt;

  // poll evaluation of the status byte
  logic [15:0] limit;
  logic [16:0] pc_inc;
  logic        want_drq, cond, poll_done;
  logic [2:0]  poll_code;
  logic [7:0]  sel;
  logic [1:0]  att_inc;
  logic [7:0]  left_dec;

  function automatic result_t mk_res(logic [2:0] k, logic ch, logic [2:0] r,
                                     logic [15:0] v, logic [2:0] c);
    result_t res;
    res.out_kind    = k;
    res.channel     = ch;
    res.reg_offset  = r;
    res.value       = v;
    res.result_code = c;
    res.last        = 1'b0;
    return res;
  endfunction

  function automatic burst_t single(result_t res);
    burst_t b;
    b          = '0;
    b.n        = CNT_W'(1);
    b.items[0] = res;
    b.items[0].last = 1'b1;
    return b;
  endfunction

  function automatic burst_t taskfile(logic ch, logic [7:0] cnt, logic [27:0] a,
                                      logic [7:0] s, logic [7:0] cmd);
    burst_t b;
    b          = '0;
    b.n        = CNT_W'(BURST_MAX);
    b.items[0] = mk_res(OK_REG_WR, ch, REG_COUNT, {8'h00, cnt}, RC_OK);
    b.items[1] = mk_res(OK_REG_WR, ch, REG_LBA_LO, {8'h00, a[7:0]}, RC_OK);
    b.items[2] = mk_res(OK_REG_WR, ch, REG_LBA_MID, {8'h00, a[15:8]}, RC_OK);
    b.items[3] = mk_res(OK_REG_WR, ch, REG_LBA_HI, {8'h00, a[23:16]}, RC_OK);
    b.items[4] = mk_res(OK_REG_WR, ch, REG_HEAD, {8'h00, s | {4'h0, a[27:24]}}, RC_OK);
    b.items[5] = mk_res(OK_REG_WR, ch, REG_CMD, {8'h00, cmd}, RC_OK);
    b.items[5].last = 1'b1;
    return b;
  endfunction

  always_comb begin
    limit    = (cfg.poll_limit == 16'd0) ? 16'd1 : cfg.poll_limit;
    pc_inc   = {1'b0, pc_r} + 17'd1;
    want_drq = (phase_r == PH_RD_DRQ) || (phase_r == PH_WR_DRQ);
    cond     = want_drq ? item.status_byte[ST_DRQ] : !item.status_byte[ST_BSY];
    poll_done = 1'b1;
    poll_code = RC_OK;
    if (item.status_byte == STAT_FLOAT) begin
      poll_code = RC_FLOATING;
    end else if (item.status_byte[ST_ERR]) begin
      poll_code = RC_ERROR;
    end else if (item.status_byte[ST_DF]) begin
      poll_code = RC_FAULT;
    end else if (cond) begin
      poll_code = RC_OK;
    end else if (pc_inc >= {1'b0, limit}) begin
      poll_code = want_drq ? RC_DRQ_TO : RC_BSY_TO;
    end else begin
      poll_done = 1'b0;
    end
  end

  assign sel      = drive_r[0] ? SEL_SLAVE : SEL_MASTER;
  assign att_inc  = attempt_r + 2'd1;
  assign left_dec = left_r - 8'd1;

  always_comb begin
    phase_nxt   = phase_r;
    drive_nxt   = drive_r;
    lba_nxt     = lba_r;
    left_nxt    = left_r;
    widx_nxt    = widx_r;
    pc_nxt      = pc_r;
    attempt_nxt = attempt_r;
    burst       = '0;
    if (fire) begin
      case (item.kind)
        KIND_START: begin
          if (phase_r != PH_IDLE) begin
            burst = single(mk_res(OK_DONE, item.drive[1], REG_DATA, 16'h0000, RC_REJECT));
          end else if (({1'b0, item.drive} >= DRIVES_LIM) || !cfg.present_mask[item.drive] ||
                       (item.sector_count == 8'd0)) begin
            drive_nxt = item.drive;
            burst = single(mk_res(OK_DONE, item.drive[1], REG_DATA, 16'h0000, RC_REJECT));
          end else begin
            drive_nxt   = item.drive;
            lba_nxt     = item.lba;
            left_nxt    = item.sector_count;
            widx_nxt    = '0;
            attempt_nxt = 2'd0;
            pc_nxt      = 16'd0;
            phase_nxt   = item.op_write ? PH_WR_READY : PH_RD_PRE;
            burst = single(mk_res(OK_REG_WR, item.drive[1], REG_HEAD,
                                  {8'h00, item.drive[0] ? SEL_SLAVE : SEL_MASTER}, RC_OK));
          end
        end
        KIND_STATUS: begin
          if (phase_r == PH_RD_RECOVER || phase_r == PH_RD_PRE || phase_r == PH_RD_DRQ ||
              phase_r == PH_RD_POST || phase_r == PH_WR_READY || phase_r == PH_WR_DRQ ||
              phase_r == PH_WR_FINAL) begin
            if (!poll_done) begin
              pc_nxt = pc_inc[15:0];
            end else if (phase_r == PH_RD_RECOVER) begin
              // recovery wait ends on any outcome
              phase_nxt = PH_RD_PRE;
              pc_nxt    = 16'd0;
              burst = single(mk_res(OK_REG_WR, drive_r[1], REG_HEAD, {8'h00, sel}, RC_OK));
            end else if (poll_code == RC_OK) begin
              case (phase_r)
                PH_RD_PRE: begin
                  burst     = taskfile(drive_r[1], 8'd1, lba_r, sel, CMD_READ);
                  phase_nxt = PH_RD_DRQ;
                  pc_nxt    = 16'd0;
                end
                PH_RD_DRQ: begin
                  phase_nxt = PH_RD_DATA;
                  widx_nxt  = '0;
                end
                PH_RD_POST: begin
                  left_nxt = left_dec;
                  if (left_dec == 8'd0) begin
                    phase_nxt = PH_IDLE;
                    burst = single(mk_res(OK_DONE, drive_r[1], REG_DATA, 16'h0000, RC_OK));
                  end else begin
                    lba_nxt     = lba_r + 28'd1;
                    attempt_nxt = 2'd0;
                    phase_nxt   = PH_RD_PRE;
                    pc_nxt      = 16'd0;
                    burst = single(mk_res(OK_REG_WR, drive_r[1], REG_HEAD, {8'h00, sel},
                                          RC_OK));
                  end
                end
                PH_WR_READY: begin
                  burst     = taskfile(drive_r[1], left_r, lba_r, sel, CMD_WRITE);
                  phase_nxt = PH_WR_DRQ;
                  pc_nxt    = 16'd0;
                end
                PH_WR_DRQ: begin
                  phase_nxt = PH_WR_DATA;
                  widx_nxt  = '0;
                end
                default: begin
                  // final write poll
                  phase_nxt = PH_IDLE;
                  burst = single(mk_res(OK_DONE, drive_r[1], REG_DATA, 16'h0000, RC_OK));
                end
              endcase
            end else if (phase_r == PH_RD_PRE || phase_r == PH_RD_DRQ ||
                         phase_r == PH_RD_POST) begin
              // read failure: retry after an error read, or give up
              attempt_nxt = att_inc;
              if (att_inc < ATTEMPT_LIM) begin
                phase_nxt = PH_RD_RECOVER;
                pc_nxt    = 16'd0;
                burst = single(mk_res(OK_ERR_RD, drive_r[1], REG_ERROR, 16'h0000, RC_OK));
              end else begin
                phase_nxt = PH_IDLE;
                burst = single(mk_res(OK_DONE, drive_r[1], REG_DATA, 16'h0000, poll_code));
              end
            end else begin
              phase_nxt = PH_IDLE;
              burst = single(mk_res(OK_DONE, drive_r[1], REG_DATA, 16'h0000, poll_code));
            end
          end
        end
        KIND_DATA: begin
          if (phase_r == PH_RD_DATA || phase_r == PH_WR_DATA) begin
            burst = single(mk_res((phase_r == PH_RD_DATA) ? OK_TO_HOST : OK_TO_DEV,
                                  drive_r[1], REG_DATA, item.data_word, RC_OK));
            widx_nxt = widx_r + WIDX_W'(1);
            if (widx_r == LAST_WORD) begin
              widx_nxt = '0;
              pc_nxt   = 16'd0;
              if (phase_r == PH_RD_DATA) begin
                phase_nxt = PH_RD_POST;
              end else begin
                left_nxt  = left_dec;
                phase_nxt = (left_dec != 8'd0) ? PH_WR_DRQ : PH_WR_FINAL;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      drive_r   <= 2'd0;
      lba_r     <= 28'd0;
      left_r    <= 8'd0;
      widx_r    <= '0;
      pc_r      <= 16'd0;
      attempt_r <= 2'd0;
    end else begin
      phase_r   <= phase_nxt;
      drive_r   <= drive_nxt;
      lba_r     <= lba_nxt;
      left_r    <= left_nxt;
      widx_r    <= widx_nxt;
      pc_r      <= pc_nxt;
      attempt_r <= attempt_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/apcs_burst.sv =====
// apcs_burst: result register that holds one item's burst of results and
// drains it one word per cycle while out_ch.ready is high. Depends on apcs_pkg and apcs_out_if.
`default_nettype none

module apcs_burst (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             fire,
  input  apcs_pkg::burst_t burst,
  output logic             take_ok,
  apcs_out_if.source       out_ch
);
  import apcs_pkg::*;

  result_t [BURST_MAX-1:0] q_r, q_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic                    pop, load;

  assign pop  = out_ch.valid && out_ch.ready;
  assign load = fire && (burst.n != '0);

  // free, or its final word leaves this cycle
  assign take_ok = (cnt_r == '0) || ((cnt_r == CNT_W'(1)) && out_ch.ready);

  always_comb begin
    q_nxt   = q_r;
    cnt_nxt = cnt_r;
    if (load) begin
      q_nxt   = burst.items;
      cnt_nxt = burst.n;
    end else if (pop) begin
      q_nxt   = {q_r[BURST_MAX-1], q_r[BURST_MAX-1:1]};
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign out_ch.valid       = (cnt_r != '0);
  assign out_ch.out_kind    = q_r[0].out_kind;
  assign out_ch.channel     = q_r[0].channel;
  assign out_ch.reg_offset  = q_r[0].reg_offset;
  assign out_ch.value       = q_r[0].value;
  assign out_ch.result_code = q_r[0].result_code;
  assign out_ch.last        = q_r[0].last;

endmodule

`default_nettype wire
